/* rtl/twg_pkg.sv */
// shared types, format codes and defaults for the ternary-weight gemv row engine
package twg_pkg;

    // weight format codes
    localparam logic [2:0] FMT_INT8      = 3'd0;
    localparam logic [2:0] FMT_TWO_BIT   = 3'd1;
    localparam logic [2:0] FMT_BASE3     = 3'd2;
    localparam logic [2:0] FMT_FOLD9     = 3'd3;
    localparam logic [2:0] FMT_K3        = 3'd4;
    localparam logic [2:0] FMT_MASK_SIGN = 3'd5;

    // register map (byte addresses)
    localparam logic [2:0] ADDR_WEIGHT_FORMAT = 3'd0;

    // default fraction bits of the group scales
    localparam int SCALE_FRAC_BITS_DEF = 16;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic corr;
        logic absv;
        logic mul0;
        logic mul1;
        logic scale;
        logic acc;
        logic emit;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

/* rtl/twg_ctrl.sv */
// controller state machine: element accept, group close sequence, row emit
module twg_ctrl import twg_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  logic     i_last_in_group,
    input  logic     i_last_in_row,
    input  t_dp_stat i_stat,
    output logic     o_ready,
    output t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CORR  = 3'd1;
    localparam logic [2:0] S_ABS   = 3'd2;
    localparam logic [2:0] S_MUL0  = 3'd3;
    localparam logic [2:0] S_MUL1  = 3'd4;
    localparam logic [2:0] S_SCALE = 3'd5;
    localparam logic [2:0] S_ACC   = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_row_pend, n_row_pend;
    logic       accept;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_row_pend = r_row_pend;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.accept = 1'b1;
                    n_row_pend   = i_last_in_row;
                    if (i_last_in_group) begin
                        n_state = S_CORR;
                    end else if (i_last_in_row) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_CORR: begin
                o_cmd.corr = 1'b1;
                n_state    = S_ABS;
            end
            S_ABS: begin
                o_cmd.absv = 1'b1;
                n_state    = S_MUL0;
            end
            S_MUL0: begin
                o_cmd.mul0 = 1'b1;
                n_state    = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = r_row_pend ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                // wait for the output register to be free
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_row_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_row_pend <= n_row_pend;
        end
    end

endmodule

/* rtl/twg_dp.sv */
// datapath: weight decode, group dot product, group scaling and row accumulator
module twg_dp import twg_pkg::*; #(
    parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic [2:0]         i_fmt,
    input  logic signed [7:0]  i_activation,
    input  logic [7:0]         i_weight_byte,
    input  logic [7:0]         i_second_byte,
    input  logic [5:0]         i_element_index,
    input  logic signed [13:0] i_group_sum,
    input  logic signed [23:0] i_weight_scale,
    input  logic [22:0]        i_act_scale,
    input  logic               i_last_in_group,
    input  logic               i_last_in_row,
    input  logic               i_out_ready,
    output t_dp_stat           o_stat,
    output logic               o_out_valid,
    output logic [63:0]        o_out_data
);

    // shift from 2*frac bits to 32 fraction bits
    localparam int SH   = 2 * SCALE_FRAC_BITS - 32;
    localparam int RSH  = (SH > 0) ? SH : 0;
    localparam int LSH  = (SH < 0) ? -SH : 0;
    localparam int PW   = 70;
    localparam int EW   = PW + LSH + 1;
    localparam logic [EW-1:0] HALF = (RSH > 0) ? (EW'(1) << ((RSH > 0) ? RSH - 1 : 0)) : '0;
    localparam logic [EW-1:0] LIM_POS = EW'({1'b0, {63{1'b1}}});
    localparam logic [EW-1:0] LIM_NEG = EW'({1'b1, {63{1'b0}}});

    // divide an 8-bit value by three through the reciprocal
    function automatic logic [7:0] div3(input logic [7:0] v);
        logic [15:0] p;
        p = v * 8'd171;
        return {1'b0, p[15:9]};
    endfunction

    // divide an 8-bit value by nine through the reciprocal
    function automatic logic [7:0] div9(input logic [7:0] v);
        logic [15:0] p;
        p = v * 8'd57;
        return {1'b0, p[15:9]};
    endfunction

    // divide an 8-bit value by 27 through the reciprocal
    function automatic logic [7:0] div27(input logic [7:0] v);
        logic [15:0] p;
        p = v * 8'd19;
        return {1'b0, p[15:9]};
    endfunction

    logic signed [23:0] r_gd;
    logic [23:0]        r_gd_close;
    logic [3:0]         r_bias;
    logic signed [13:0] r_gs;
    logic [23:0]        r_wsmag;
    logic               r_wsneg;
    logic [22:0]        r_as;
    logic signed [24:0] r_corr;
    logic [45:0]        r_bmag;
    logic [23:0]        r_amag;
    logic               r_neg;
    logic [PW-1:0]      r_prod;
    logic [63:0]        r_smag;
    logic signed [63:0] r_acc;
    logic               r_out_valid;
    logic [63:0]        r_out_data;

    // element decode
    logic [1:0]         two;
    logic [3:0]         nib;
    logic [3:0]         snib;
    logic [2:0]         bitp;
    logic [9:0]         q13;
    logic [3:0]         q5;
    logic [5:0]         r6;
    logic [7:0]         v1, v2, v3, v4, vr, q3, d8;
    logic signed [7:0]  code;
    logic [3:0]         bias;
    logic signed [15:0] prod;
    logic signed [23:0] gd_sum;
    logic [23:0]        ws_abs;

    always_comb begin
        two  = 2'(i_weight_byte >> {i_element_index[1:0], 1'b0});
        nib  = i_element_index[0] ? i_weight_byte[7:4] : i_weight_byte[3:0];
        snib = i_element_index[0] ? i_second_byte[7:4] : i_second_byte[3:0];
        bitp = i_element_index[2:0];
        // index mod 5 by reciprocal multiply
        q13  = i_element_index * 4'd13;
        q5   = q13[9:6];
        r6   = i_element_index - q5 * 3'd5;
        // byte divided by 3, 9, 27 and 81 side by side, digit picked by the remainder
        v1 = div3(i_weight_byte);
        v2 = div9(i_weight_byte);
        v3 = div27(i_weight_byte);
        v4 = (i_weight_byte >= 8'd243) ? 8'd3 :
             (i_weight_byte >= 8'd162) ? 8'd2 :
             (i_weight_byte >= 8'd81)  ? 8'd1 : 8'd0;
        case (r6[2:0])
            3'd0:    vr = i_weight_byte;
            3'd1:    vr = v1;
            3'd2:    vr = v2;
            3'd3:    vr = v3;
            default: vr = v4;
        endcase
        q3 = div3(vr);
        d8 = vr - {q3[6:0], 1'b0} - q3;
        case (i_fmt)
            FMT_INT8: begin
                code = $signed(i_weight_byte);
                bias = 4'd0;
            end
            FMT_TWO_BIT: begin
                code = $signed({6'b0, two});
                bias = 4'd1;
            end
            FMT_BASE3: begin
                code = $signed({6'b0, d8[1:0]});
                bias = 4'd1;
            end
            FMT_FOLD9: begin
                code = $signed({4'b0, nib});
                bias = 4'd4;
            end
            FMT_K3: begin
                code = $signed({3'b0, two, 3'b0} + {6'b0, two} + {4'b0, snib});
                bias = 4'd13;
            end
            FMT_MASK_SIGN: begin
                if (!i_weight_byte[bitp]) begin
                    code = 8'sd0;
                end else if (i_second_byte[bitp]) begin
                    code = -8'sd1;
                end else begin
                    code = 8'sd1;
                end
                bias = 4'd0;
            end
            default: begin
                code = 8'sd0;
                bias = 4'd0;
            end
        endcase
        prod   = code * i_activation;
        gd_sum = r_gd + {{8{prod[15]}}, prod};
        ws_abs = i_weight_scale[23] ? 24'(-i_weight_scale) : i_weight_scale;
    end

    // group close arithmetic
    logic signed [18:0] bg;
    logic signed [24:0] corr;
    logic [24:0]        corr_abs;
    logic [46:0]        bmag_full;
    logic [46:0]        pp0, pp1;
    logic [EW-1:0]      ext, scaled, limit;
    logic [63:0]        term;
    logic signed [64:0] acc_sum;
    logic signed [63:0] acc_next;

    always_comb begin
        bg        = $signed({1'b0, r_bias}) * r_gs;
        corr      = $signed({r_gd_close[23], r_gd_close}) - $signed({{6{bg[18]}}, bg});
        bmag_full = r_wsmag * r_as;
        corr_abs  = r_corr[24] ? 25'(-r_corr) : r_corr;
        pp0       = r_amag * r_bmag[22:0];
        pp1       = r_amag * r_bmag[45:23];
        // rounding shift to 32 fraction bits, ties away from zero on the magnitude
        ext       = EW'(r_prod);
        scaled    = ((ext + HALF) >> RSH) << LSH;
        limit     = r_neg ? LIM_NEG : LIM_POS;
        term      = r_neg ? 64'(-r_smag) : r_smag;
        acc_sum   = {r_acc[63], r_acc} + {term[63], term};
        if (acc_sum[64] != acc_sum[63]) begin
            acc_next = acc_sum[64] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
        end else begin
            acc_next = acc_sum[63:0];
        end
    end

    // control-state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gd        <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_gd <= (i_last_in_group || i_last_in_row) ? '0 : gd_sum;
            end
            if (i_cmd.emit) begin
                r_acc <= '0;
            end else if (i_cmd.acc) begin
                r_acc <= acc_next;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_gd_close <= gd_sum;
            r_bias     <= bias;
            r_gs       <= i_group_sum;
            r_wsmag    <= ws_abs;
            r_wsneg    <= i_weight_scale[23];
            r_as       <= i_act_scale;
        end
        if (i_cmd.corr) begin
            r_corr <= corr;
            r_bmag <= bmag_full[45:0];
        end
        if (i_cmd.absv) begin
            r_amag <= corr_abs[23:0];
            r_neg  <= r_corr[24] ^ r_wsneg;
        end
        if (i_cmd.mul0) begin
            r_prod <= PW'(pp0);
        end
        if (i_cmd.mul1) begin
            r_prod <= r_prod + (PW'(pp1) << 23);
        end
        if (i_cmd.scale) begin
            r_smag <= (scaled > limit) ? limit[63:0] : scaled[63:0];
        end
        if (i_cmd.emit) begin
            r_out_data <= r_acc;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;

endmodule

/* rtl/ternary_weight_gemv_row.sv */
// top level of the ternary-weight gemv row engine
// an ordinary element item is taken in the idle state; an item that closes a group then
// runs the shared correction, absolute value, multiply, scaling and accumulate sequence;
// a row end then loads the output register (and waits while it is still full).
// throughput: 1 item per cycle inside a group; none is taken during a group close or row emit.
// reset: synchronous active low, clears the dot and row accumulators, the output
// valid and the controller; weight_format returns to two-bit (1).
module ternary_weight_gemv_row import twg_pkg::*; #(
    parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // activation, weight_byte, second_byte, element_index, group_sum,
    // weight_scale, act_scale, then 5 zero bits
    input  logic [95:0] s_axis_tdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic        s_axis_tlast,   // last_in_row
    input  logic        s_axis_tuser,   // last_in_group
    // row_value
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [2:0] r_fmt;
    t_dp_cmd    cmd;
    t_dp_stat   stat;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_TWO_BIT;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == ADDR_WEIGHT_FORMAT[2])) begin
            r_fmt <= pwdata[2:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_WEIGHT_FORMAT[2]) ? {29'b0, r_fmt} : 32'b0;

    twg_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s_axis_tvalid),
        .i_last_in_group (s_axis_tuser),
        .i_last_in_row   (s_axis_tlast),
        .i_stat          (stat),
        .o_ready         (s_axis_tready),
        .o_cmd           (cmd)
    );

    twg_dp #(
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_fmt           (r_fmt),
        .i_activation    ($signed(s_axis_tdata[7:0])),
        .i_weight_byte   (s_axis_tdata[15:8]),
        .i_second_byte   (s_axis_tdata[23:16]),
        .i_element_index (s_axis_tdata[29:24]),
        .i_group_sum     ($signed(s_axis_tdata[43:30])),
        .i_weight_scale  ($signed(s_axis_tdata[67:44])),
        .i_act_scale     (s_axis_tdata[90:68]),
        .i_last_in_group (s_axis_tuser),
        .i_last_in_row   (s_axis_tlast),
        .i_out_ready     (m_axis_tready),
        .o_stat          (stat),
        .o_out_valid     (m_axis_tvalid),
        .o_out_data      (m_axis_tdata)
    );

endmodule

/* rtl/twg_checker.sv */
// port-level checker for the gemv row engine and its bind to the top level
module twg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready
);

    // a result item waiting for the sink stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result item dropped while stalled");

    // an item inside a group leaves the block ready for the next one
    a_plain_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tlast && !s_axis_tuser |=> s_axis_tready)
        else $error("input stalled after a plain element item");

    // a group or row end occupies the block in the following cycle
    a_close_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tlast || s_axis_tuser) |=> !s_axis_tready)
        else $error("input taken during group close or row emit");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid out of reset");

endmodule

bind ternary_weight_gemv_row twg_checker u_twg_checker (.*);
